[rtl/core/pileup_base_counter_top_defines.svh]
// assertion macros for the pileup base counter
// used by the rtl/core modules that carry concurrent checks
`ifndef PILEUP_BASE_COUNTER_TOP_DEFINES_SVH
`define PILEUP_BASE_COUNTER_TOP_DEFINES_SVH

// same-cycle implication
`define PBC_CHECK_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("pbc check failed");

// next-cycle implication
`define PBC_CHECK_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("pbc check failed");

`endif

[rtl/core/pbc_pkg.sv]
// shared types, constants and helpers for the pileup base counter
// no dependencies
package pbc_pkg;

   localparam int COUNT_BITS = 16;
   localparam int NUM_CAT    = 14;
   localparam int CAT_W      = 4;
   localparam int WIDE_BITS  = (COUNT_BITS > 16) ? COUNT_BITS : 16;

   localparam logic [CAT_W-1:0] CAT_REF     = 4'd0;
   localparam logic [CAT_W-1:0] CAT_REV_OFS = 4'd5;
   localparam logic [CAT_W-1:0] CAT_STAR    = 4'd11;
   localparam logic [CAT_W-1:0] CAT_HASH    = 4'd12;
   localparam logic [CAT_W-1:0] CAT_INS     = 4'd13;
   localparam logic [CAT_W-1:0] CAT_LAST    = 4'd13;

   typedef logic [COUNT_BITS-1:0] count_type;

   localparam count_type COUNT_MAX = {COUNT_BITS{1'b1}};

   typedef struct packed {
      logic [7:0] symbol;
      logic [7:0] ref_letter;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [3:0]  category;
      logic [15:0] count;
      logic        status;
      logic        end_of_line;
   } rsp_type;

   // one counter update, launched at the byte transfer
   typedef struct packed {
      logic             valid;
      logic [CAT_W-1:0] cat;
      logic             inc;
      logic             last;
      logic             emit;
   } upd_type;

   // per-line values captured at the last byte
   typedef struct packed {
      count_type  fwd;
      count_type  rev;
      logic       err;
      logic [2:0] slot;
   } line_type;

   function automatic count_type sat_inc(count_type v);
      return (v == COUNT_MAX) ? v : count_type'(v + 1'b1);
   endfunction

   function automatic logic [15:0] clip16(count_type v);
      logic [WIDE_BITS-1:0] w;
      w = WIDE_BITS'(v);
      return (w > WIDE_BITS'(16'hFFFF)) ? 16'hFFFF : w[15:0];
   endfunction

endpackage

[rtl/core/pbc_parser.sv]
// byte parser: phase tracking, match counts, error and filter state
// depends on pbc_pkg
module pbc_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  pbc_pkg::req_type  req_data,
   input  logic              csr_we,
   input  logic              csr_wdata,
   output pbc_pkg::upd_type  upd,
   output logic              line_start,
   output pbc_pkg::line_type line_info
);
   import pbc_pkg::*;

   typedef enum logic [1:0] {
      PH_NORMAL  = 2'd0,
      PH_DIGITS  = 2'd1,
      PH_SKIP    = 2'd2,
      PH_SKIPONE = 2'd3
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] len_ff, len_in;
   count_type   fwd_ff, fwd_in;
   count_type   rev_ff, rev_in;
   logic        err_ff, err_in;
   logic        del_ff, del_in;
   logic        filter_ff, filter_in;
   line_type    line_ff, line_in;

   logic             accept;
   logic             run_normal;
   logic             inc;
   logic [CAT_W-1:0] cat;
   logic [7:0]       sym;
   logic             is_digit;
   logic [19:0]      acc;
   logic [15:0]      len_sat;
   logic             emit;
   logic [2:0]       slot;

   assign accept   = req_valid & req_ready;
   assign sym      = req_data.symbol;
   assign is_digit = (sym >= "0") && (sym <= "9");
   assign acc      = 20'({len_ff, 3'b000}) + 20'({len_ff, 1'b0}) + 20'(sym[3:0]);
   assign len_sat  = (acc > 20'd65535) ? 16'hFFFF : acc[15:0];

   always_comb begin
      unique case (req_data.ref_letter)
         "A", "a": slot = 3'd1;
         "C", "c": slot = 3'd2;
         "G", "g": slot = 3'd3;
         "T", "t": slot = 3'd4;
         "N", "n": slot = 3'd5;
         default:  slot = 3'd0;
      endcase
   end

   always_comb begin
      phase_in   = phase_ff;
      len_in     = len_ff;
      fwd_in     = fwd_ff;
      rev_in     = rev_ff;
      err_in     = err_ff;
      del_in     = del_ff;
      run_normal = 1'b0;
      inc        = 1'b0;
      cat        = CAT_REF;
      if (accept) begin
         case (phase_ff)
            PH_DIGITS: begin
               if (is_digit) begin
                  len_in = len_sat;
               end else if (len_ff == 16'd0) begin
                  phase_in   = PH_NORMAL;
                  run_normal = 1'b1;
               end else begin
                  len_in   = len_ff - 16'd1;
                  phase_in = (len_ff != 16'd1) ? PH_SKIP : PH_NORMAL;
               end
            end
            PH_SKIP: begin
               if (len_ff != 16'd0) begin
                  len_in = len_ff - 16'd1;
               end
               if (len_ff <= 16'd1) begin
                  phase_in = PH_NORMAL;
               end
            end
            PH_SKIPONE: phase_in = PH_NORMAL;
            default:    run_normal = 1'b1;
         endcase
         if (run_normal) begin
            unique case (sym)
               ".": fwd_in = sat_inc(fwd_ff);
               ",": rev_in = sat_inc(rev_ff);
               "A": begin inc = 1'b1; cat = 4'd1; end
               "C": begin inc = 1'b1; cat = 4'd2; end
               "G": begin inc = 1'b1; cat = 4'd3; end
               "T": begin inc = 1'b1; cat = 4'd4; end
               "N": begin inc = 1'b1; cat = 4'd5; end
               "a": begin inc = 1'b1; cat = 4'd6; end
               "c": begin inc = 1'b1; cat = 4'd7; end
               "g": begin inc = 1'b1; cat = 4'd8; end
               "t": begin inc = 1'b1; cat = 4'd9; end
               "n": begin inc = 1'b1; cat = 4'd10; end
               "*": begin inc = 1'b1; cat = CAT_STAR; del_in = 1'b1; end
               "#": begin inc = 1'b1; cat = CAT_HASH; del_in = 1'b1; end
               "+": begin
                  inc      = 1'b1;
                  cat      = CAT_INS;
                  phase_in = PH_DIGITS;
                  len_in   = 16'd0;
               end
               "-": begin
                  phase_in = PH_DIGITS;
                  len_in   = 16'd0;
               end
               "^": phase_in = PH_SKIPONE;
               "<", ">", "$": ;
               default: err_in = 1'b1;
            endcase
         end
      end
      emit    = ~filter_ff | del_in;
      line_in = '{fwd: fwd_in, rev: rev_in, err: err_in, slot: slot};
      // line end clears all parse state
      if (accept && req_data.last) begin
         phase_in = PH_NORMAL;
         len_in   = 16'd0;
         fwd_in   = '0;
         rev_in   = '0;
         err_in   = 1'b0;
         del_in   = 1'b0;
      end
   end

   assign filter_in = csr_we ? csr_wdata : filter_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_NORMAL;
         len_ff    <= '0;
         fwd_ff    <= '0;
         rev_ff    <= '0;
         err_ff    <= 1'b0;
         del_ff    <= 1'b0;
         filter_ff <= 1'b1;
      end else begin
         phase_ff  <= phase_in;
         len_ff    <= len_in;
         fwd_ff    <= fwd_in;
         rev_ff    <= rev_in;
         err_ff    <= err_in;
         del_ff    <= del_in;
         filter_ff <= filter_in;
      end
      if (accept && req_data.last) begin
         line_ff <= line_in;
      end
   end

   assign upd = '{valid: accept, cat: cat, inc: inc, last: req_data.last, emit: emit};
   assign line_start = accept & req_data.last & emit;
   assign line_info  = line_ff;

endmodule

[rtl/core/pbc_count_ram.sv]
// category counter memory: synchronous read, read-modify-write with forwarding
// per-entry valid bits give zero for entries not written in the current line
// depends on pbc_pkg
module pbc_count_ram (
   input  logic                      clock,
   input  logic                      reset,
   input  pbc_pkg::upd_type          upd,
   input  logic [pbc_pkg::CAT_W-1:0] drain_addr,
   input  logic                      drain_clear,
   output pbc_pkg::count_type        rd_count
);
   import pbc_pkg::*;

   count_type          mem_ff [NUM_CAT];
   logic [NUM_CAT-1:0] vld_ff;

   count_type        rd_data_ff;
   logic             rd_ok_ff;
   upd_type          s1_ff;
   logic             lw_valid_ff;
   logic [CAT_W-1:0] lw_cat_ff;
   count_type        lw_data_ff;
   logic             clr_d_ff;

   logic [CAT_W-1:0] rd_addr;
   count_type        base;
   count_type        wr_data;
   logic             wr_en;
   logic             drop_line;
   logic             clr_all;

   assign rd_addr   = upd.valid ? upd.cat : drain_addr;
   assign rd_count  = (rd_ok_ff && !clr_d_ff) ? rd_data_ff : '0;
   assign base      = (lw_valid_ff && (lw_cat_ff == s1_ff.cat)) ? lw_data_ff : rd_count;
   assign wr_data   = sat_inc(base);
   assign drop_line = s1_ff.valid & s1_ff.last & ~s1_ff.emit;
   assign wr_en     = s1_ff.valid & s1_ff.inc & ~drop_line;
   assign clr_all   = drop_line | drain_clear;

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
      if (wr_en) begin
         mem_ff[s1_ff.cat] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         rd_ok_ff    <= 1'b0;
         s1_ff       <= '0;
         lw_valid_ff <= 1'b0;
         clr_d_ff    <= 1'b0;
      end else begin
         rd_ok_ff    <= vld_ff[rd_addr];
         s1_ff       <= upd;
         lw_valid_ff <= wr_en;
         clr_d_ff    <= clr_all;
         if (clr_all) begin
            vld_ff <= '0;
         end else if (wr_en) begin
            vld_ff[s1_ff.cat] <= 1'b1;
         end
      end
      lw_cat_ff  <= s1_ff.cat;
      lw_data_ff <= wr_data;
   end

endmodule

[rtl/core/pbc_drain.sv]
// line drain: reads the fourteen counts, applies reference substitution,
// holds the result register; depends on pbc_pkg and the defines header
`include "pileup_base_counter_top_defines.svh"

module pbc_drain (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      line_start,
   input  pbc_pkg::line_type         line_info,
   input  pbc_pkg::count_type        rd_count,
   output logic [pbc_pkg::CAT_W-1:0] drain_addr,
   output logic                      drain_clear,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output pbc_pkg::rsp_type          rsp_data
);
   import pbc_pkg::*;

   typedef enum logic [1:0] {
      ST_PARSE  = 2'd0,
      ST_SETTLE = 2'd1,
      ST_DRAIN  = 2'd2,
      ST_TAIL   = 2'd3
   } state_type;

   state_type        state_ff, state_in;
   logic [CAT_W-1:0] idx_ff, idx_in;
   logic             fly_ff, fly_in;
   logic [CAT_W-1:0] fly_cat_ff, fly_cat_in;
   logic             out_valid_ff, out_valid_in;
   rsp_type          out_ff, out_in;

   logic                issue;
   logic [COUNT_BITS:0] sum;
   count_type           ref_count;
   count_type           value;
   logic [CAT_W-1:0]    slot_fwd;
   logic [CAT_W-1:0]    slot_rev;

   assign issue     = (state_ff == ST_DRAIN) && !fly_ff && (!out_valid_ff || rsp_ready);
   assign sum       = {1'b0, line_info.fwd} + {1'b0, line_info.rev};
   assign ref_count = sum[COUNT_BITS] ? COUNT_MAX : sum[COUNT_BITS-1:0];
   assign slot_fwd  = CAT_W'(line_info.slot);
   assign slot_rev  = CAT_W'(line_info.slot) + CAT_REV_OFS;

   always_comb begin
      if (fly_cat_ff == CAT_REF) begin
         value = ref_count;
      end else if (line_info.slot != 3'd0 && fly_cat_ff == slot_fwd) begin
         value = line_info.fwd;
      end else if (line_info.slot != 3'd0 && fly_cat_ff == slot_rev) begin
         value = line_info.rev;
      end else begin
         value = rd_count;
      end
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      fly_in       = 1'b0;
      fly_cat_in   = fly_cat_ff;
      out_valid_in = out_valid_ff & ~rsp_ready;
      out_in       = out_ff;
      if (fly_ff) begin
         out_valid_in = 1'b1;
         out_in = '{category: fly_cat_ff, count: clip16(value), status: line_info.err,
                    end_of_line: (fly_cat_ff == CAT_LAST)};
      end
      unique case (state_ff)
         ST_PARSE: begin
            if (line_start) begin
               state_in = ST_SETTLE;
            end
         end
         ST_SETTLE: begin
            state_in = ST_DRAIN;
            idx_in   = CAT_REF;
         end
         ST_DRAIN: begin
            if (issue) begin
               fly_in     = 1'b1;
               fly_cat_in = idx_ff;
               idx_in     = idx_ff + 1'b1;
               if (idx_ff == CAT_LAST) begin
                  state_in = ST_TAIL;
               end
            end
         end
         ST_TAIL: begin
            if (fly_ff) begin
               state_in = ST_PARSE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_PARSE;
         idx_ff       <= '0;
         fly_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         fly_ff       <= fly_in;
         out_valid_ff <= out_valid_in;
      end
      fly_cat_ff <= fly_cat_in;
      out_ff     <= out_in;
   end

   assign drain_addr  = idx_ff;
   assign drain_clear = fly_ff & (state_ff == ST_TAIL);
   assign req_ready   = (state_ff == ST_PARSE);
   assign rsp_valid   = out_valid_ff;
   assign rsp_data    = out_ff;

   `PBC_CHECK_IMPLY(a_land_slot_free, clock, reset, fly_ff, !out_valid_ff)
   `PBC_CHECK_IMPLY(a_no_read_in_parse, clock, reset, state_ff == ST_PARSE, !fly_ff)
   `PBC_CHECK_NEXT(a_tail_ends_line, clock, reset, (state_ff == ST_TAIL) && fly_ff, out_valid_ff && out_ff.end_of_line && req_ready)

endmodule

[rtl/core/pileup_base_counter_top.sv]
// pileup base counter top level: parser, counter memory and drain
// depends on pbc_pkg, pbc_parser, pbc_count_ram, pbc_drain
//
//   channel   ports                        direction   unit
//   req       req_valid/req_ready/req_data  in          one bases-column byte
//   rsp       rsp_valid/rsp_ready/rsp_data  out         one category count
//   csr       csr_we/csr_wdata              in          deletion filter bit
//
// bytes of a line are taken one per cycle while req_ready is high; counters live
// in a 14-entry memory updated read-modify-write with forwarding of the last write
// after an emitted last byte the input pauses for the drain, and longer on rsp stalls:
// each count needs a read of the single memory port and a slot in the result register
// a line dropped by the filter costs no pause; counts are zero again at once
// reset is synchronous and clears control state and the per-entry valid bits
module pileup_base_counter_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pbc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pbc_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic             csr_wdata
);
   import pbc_pkg::*;

   upd_type          upd;
   logic             line_start;
   line_type         line_info;
   count_type        rd_count;
   logic [CAT_W-1:0] drain_addr;
   logic             drain_clear;

   pbc_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .upd        (upd),
      .line_start (line_start),
      .line_info  (line_info)
   );

   pbc_count_ram u_count_ram (
      .clock       (clock),
      .reset       (reset),
      .upd         (upd),
      .drain_addr  (drain_addr),
      .drain_clear (drain_clear),
      .rd_count    (rd_count)
   );

   pbc_drain u_drain (
      .clock       (clock),
      .reset       (reset),
      .line_start  (line_start),
      .line_info   (line_info),
      .rd_count    (rd_count),
      .drain_addr  (drain_addr),
      .drain_clear (drain_clear),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule
